// ===== hw/rtl/spa_pkg.sv =====
// Shared types and constants for the sparse polynomial adder.
`default_nettype none
package spa_pkg;

   localparam int MAX_TERMS_DEF = 32;
   localparam int COEF_W        = 16;
   localparam int POW_W         = 16;
   localparam int SUM_W         = COEF_W + 1;
   localparam int TERM_W        = COEF_W + POW_W;

   typedef enum logic [1:0] {
      REQ_LOAD_A = 2'd0,
      REQ_LOAD_B = 2'd1,
      REQ_ADD    = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_LOAD_OK   = 2'd0,
      STAT_LOAD_FULL = 2'd1,
      STAT_SUM_TERM  = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_MERGE = 1'b1
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/spa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module spa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sparse_polynomial_add_top.sv =====
// Sparse polynomial adder: two term lists merged in descending power order.
//
// A load request (type 0 or 1) appends one (coefficient, power) term to list
// A or list B and answers with one response; a load into a full list is
// dropped and reported. An add request walks both lists with two cursors: it
// first starts the memory reads at the head of each list and then returns one
// term per cycle while the response is not stalled (at most count A + count B
// terms), a rate set by the single read port of each list memory. Matching
// powers give the exact 17-bit sum, even a zero one; the last response of each
// request carries rsp_last. An add on two empty lists returns one empty marker.
// The lists persist across adds and are cleared only by reset. No request is
// taken while an add is being emitted.
`default_nettype none
module sparse_polynomial_add_top #(
   parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_type,
   input  wire logic signed [spa_pkg::COEF_W-1:0] req_coefficient,
   input  wire logic [spa_pkg::POW_W-1:0]         req_power,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic signed [spa_pkg::SUM_W-1:0]       rsp_sum_coefficient,
   output logic [spa_pkg::POW_W-1:0]              rsp_sum_power,
   output logic                                   rsp_last
);

   localparam int IDX_W = $clog2(MAX_TERMS);
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TERMS);

   spa_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] cur_a_ff, cur_a_in, cur_b_ff, cur_b_in;
   logic [CNT_W-1:0] cur_a_next, cur_b_next;

   logic                            valid_ff, valid_in;
   spa_pkg::status_type             status_ff, status_in;
   logic signed [spa_pkg::SUM_W-1:0] coef_ff, coef_in;
   logic [spa_pkg::POW_W-1:0]       pow_ff, pow_in;
   logic                            last_ff, last_in;

   logic                            wr_a, wr_b;
   logic [spa_pkg::TERM_W-1:0]      wr_data;
   logic [spa_pkg::TERM_W-1:0]      rd_a, rd_b;

   logic                            out_free, req_fire;
   logic                            a_has, b_has, take_a, take_b, merge_done;
   logic [spa_pkg::POW_W-1:0]       pa, pb;
   logic signed [spa_pkg::COEF_W-1:0] ca, cb;
   logic signed [spa_pkg::SUM_W-1:0]  op_a, op_b, step_sum;

   // Each list entry is stored as {coefficient, power}.
   assign wr_data = {req_coefficient, req_power};

   spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_list_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (cur_a_in[IDX_W-1:0]),
      .rd_data (rd_a)
   );

   spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_list_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (cur_b_in[IDX_W-1:0]),
      .rd_data (rd_b)
   );

   // One merge step: the power compares and a single coefficient adder.
   always_comb begin
      pa     = rd_a[spa_pkg::POW_W-1:0];
      pb     = rd_b[spa_pkg::POW_W-1:0];
      ca     = rd_a[spa_pkg::TERM_W-1:spa_pkg::POW_W];
      cb     = rd_b[spa_pkg::TERM_W-1:spa_pkg::POW_W];
      a_has  = cur_a_ff < cnt_a_ff;
      b_has  = cur_b_ff < cnt_b_ff;
      take_a = a_has && (!b_has || pa >= pb);
      take_b = b_has && (!a_has || pb >= pa);
      op_a   = take_a ? spa_pkg::SUM_W'(ca) : '0;
      op_b   = take_b ? spa_pkg::SUM_W'(cb) : '0;
      step_sum   = op_a + op_b;
      cur_a_next = cur_a_ff + CNT_W'(take_a);
      cur_b_next = cur_b_ff + CNT_W'(take_b);
      merge_done = (cur_a_next >= cnt_a_ff) && (cur_b_next >= cnt_b_ff);
   end

   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == spa_pkg::ST_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      cnt_a_in  = cnt_a_ff;
      cnt_b_in  = cnt_b_ff;
      cur_a_in  = cur_a_ff;
      cur_b_in  = cur_b_ff;
      valid_in  = valid_ff && rsp_stall;
      status_in = status_ff;
      coef_in   = coef_ff;
      pow_in    = pow_ff;
      last_in   = last_ff;
      wr_a      = 1'b0;
      wr_b      = 1'b0;
      unique case (state_ff)
         spa_pkg::ST_IDLE: begin
            if (req_fire) begin
               coef_in = '0;
               pow_in  = '0;
               last_in = 1'b1;
               unique case (spa_pkg::req_code_type'(req_type))
                  spa_pkg::REQ_LOAD_A: begin
                     valid_in = 1'b1;
                     if (cnt_a_ff == CNT_FULL) begin
                        status_in = spa_pkg::STAT_LOAD_FULL;
                     end else begin
                        status_in = spa_pkg::STAT_LOAD_OK;
                        wr_a      = 1'b1;
                        cnt_a_in  = cnt_a_ff + CNT_W'(1);
                     end
                  end
                  spa_pkg::REQ_LOAD_B: begin
                     valid_in = 1'b1;
                     if (cnt_b_ff == CNT_FULL) begin
                        status_in = spa_pkg::STAT_LOAD_FULL;
                     end else begin
                        status_in = spa_pkg::STAT_LOAD_OK;
                        wr_b      = 1'b1;
                        cnt_b_in  = cnt_b_ff + CNT_W'(1);
                     end
                  end
                  spa_pkg::REQ_ADD: begin
                     if (cnt_a_ff == '0 && cnt_b_ff == '0) begin
                        valid_in  = 1'b1;
                        status_in = spa_pkg::STAT_EMPTY;
                     end else begin
                        // Cursors restart at zero; the first reads land next cycle.
                        cur_a_in = '0;
                        cur_b_in = '0;
                        state_in = spa_pkg::ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         spa_pkg::ST_MERGE: begin
            if (out_free) begin
               valid_in  = 1'b1;
               status_in = spa_pkg::STAT_SUM_TERM;
               coef_in   = step_sum;
               pow_in    = take_a ? pa : pb;
               last_in   = merge_done;
               cur_a_in  = cur_a_next;
               cur_b_in  = cur_b_next;
               if (merge_done) begin
                  state_in = spa_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = spa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spa_pkg::ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         cur_a_ff <= '0;
         cur_b_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         cur_a_ff <= cur_a_in;
         cur_b_ff <= cur_b_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      coef_ff   <= coef_in;
      pow_ff    <= pow_in;
      last_ff   <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_sum_coefficient = coef_ff;
   assign rsp_sum_power       = pow_ff;
   assign rsp_last            = last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/spa_check.sv =====
// Port-level checker for the sparse polynomial adder and its bind.
`default_nettype none
module spa_check (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic [1:0]                        req_type,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [1:0]                        rsp_status,
   input wire logic signed [spa_pkg::SUM_W-1:0]  rsp_sum_coefficient,
   input wire logic [spa_pkg::POW_W-1:0]         rsp_sum_power,
   input wire logic                              rsp_last
);

   logic load_fire;
   assign load_fire = req_valid && !req_stall &&
      (req_type == spa_pkg::REQ_LOAD_A || req_type == spa_pkg::REQ_LOAD_B);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_sum_coefficient) && $stable(rsp_sum_power) && $stable(rsp_last))
      else $error("stalled response changed");

   // An accepted load answers in the next cycle with a single final response.
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> rsp_valid && rsp_last &&
         (rsp_status == spa_pkg::STAT_LOAD_OK || rsp_status == spa_pkg::STAT_LOAD_FULL))
      else $error("load request not answered");

   // Load and empty responses never continue a sequence.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != spa_pkg::STAT_SUM_TERM |->
         rsp_last && rsp_sum_coefficient == '0 && rsp_sum_power == '0)
      else $error("non-term response malformed");

   // No new request is taken while an add is still being emitted.
   a_busy_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken during an add");

endmodule

bind sparse_polynomial_add_top spa_check u_spa_check (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_type            (req_type),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_sum_coefficient (rsp_sum_coefficient),
   .rsp_sum_power       (rsp_sum_power),
   .rsp_last            (rsp_last)
);
`default_nettype wire

// ===== bench/sparse_polynomial_add_top_test.sv =====
// Self-checking testbench for the sparse polynomial adder: term loads and list merges.
module sparse_polynomial_add_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 320;
   localparam int NUM_DIRECTED = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      spa_pkg::status_type              status;
      logic signed [spa_pkg::SUM_W-1:0] coef;
      logic [spa_pkg::POW_W-1:0]        pow;
      logic                             last;
   } sum_term_type;

   typedef struct {
      spa_pkg::req_code_type             kind;
      logic signed [spa_pkg::COEF_W-1:0] coef;
      logic [spa_pkg::POW_W-1:0]         pow;
      bit                                typed;
      spa_pkg::status_type               want;
   } directed_req_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   spa_pkg::req_code_type             req_kind;
   logic signed [spa_pkg::COEF_W-1:0] req_coefficient;
   logic [spa_pkg::POW_W-1:0]         req_power;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [1:0]                        rsp_status;
   logic signed [spa_pkg::SUM_W-1:0]  rsp_sum_coefficient;
   logic [spa_pkg::POW_W-1:0]         rsp_sum_power;
   logic                              rsp_last;

   // Sideband for directed rows whose result is written out in the table.
   bit                                req_typed;
   spa_pkg::status_type               req_want;

   // Predictor copy of the two term lists.
   logic signed [spa_pkg::COEF_W-1:0] a_coefs [spa_pkg::MAX_TERMS_DEF];
   logic [spa_pkg::POW_W-1:0]         a_pows  [spa_pkg::MAX_TERMS_DEF];
   int                                a_fill;
   logic signed [spa_pkg::COEF_W-1:0] b_coefs [spa_pkg::MAX_TERMS_DEF];
   logic [spa_pkg::POW_W-1:0]         b_pows  [spa_pkg::MAX_TERMS_DEF];
   int                                b_fill;

   sum_term_type              step_terms[$];
   sum_term_type              awaited_terms[$];

   int                       sender_idle_pct;
   int                       receiver_idle_pct;
   int                       hold_asks;
   int                       mismatch_count;
   int                       requests_taken;
   int                       adds_taken;
   int                       dropped_loads;
   int                       zero_sums;
   int                       terms_checked;
   int                       cycle_count;

   directed_req_type directed_reqs [NUM_DIRECTED] = '{
      '{spa_pkg::REQ_ADD,         0,     0, 1'b1, spa_pkg::STAT_EMPTY},
      '{spa_pkg::REQ_NONE,        0,     0, 1'b0, spa_pkg::STAT_EMPTY},
      '{spa_pkg::REQ_LOAD_A,  32767, 65535, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_ADD,         0,     0, 1'b0, spa_pkg::STAT_EMPTY},
      '{spa_pkg::REQ_LOAD_B,  32767, 65535, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_LOAD_A, -32768,   100, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_LOAD_B, -32768,   100, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_LOAD_A,      5,     0, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_LOAD_B,     -5,     0, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_ADD,         0,     0, 1'b0, spa_pkg::STAT_EMPTY},
      '{spa_pkg::REQ_LOAD_B,      1,     5, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_LOAD_A,  21845, 43690, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_LOAD_B, -21846, 21845, 1'b1, spa_pkg::STAT_LOAD_OK},
      '{spa_pkg::REQ_ADD,     -1,    65535, 1'b0, spa_pkg::STAT_EMPTY},
      '{spa_pkg::REQ_NONE,    -1,    65535, 1'b0, spa_pkg::STAT_EMPTY},
      '{spa_pkg::REQ_ADD,         0,     0, 1'b0, spa_pkg::STAT_EMPTY}
   };

   sparse_polynomial_add_top #(
      .MAX_TERMS(spa_pkg::MAX_TERMS_DEF)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_kind),
      .req_coefficient     (req_coefficient),
      .req_power           (req_power),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_sum_coefficient (rsp_sum_coefficient),
      .rsp_sum_power       (rsp_sum_power),
      .rsp_last            (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the result terms of one accepted request into step_terms.
   function automatic void predict_request(input spa_pkg::req_code_type kind,
         input logic signed [spa_pkg::COEF_W-1:0] coef,
         input logic [spa_pkg::POW_W-1:0] pow);
      int                               ia;
      int                               ib;
      sum_term_type                     t;
      logic signed [spa_pkg::SUM_W-1:0] ca;
      logic signed [spa_pkg::SUM_W-1:0] cb;
      step_terms.delete();
      t.status = spa_pkg::STAT_LOAD_OK;
      t.coef = '0;
      t.pow = '0;
      t.last = 1'b1;
      case (kind) inside
         spa_pkg::REQ_LOAD_A, spa_pkg::REQ_LOAD_B: begin
            if ((kind == spa_pkg::REQ_LOAD_A ? a_fill : b_fill) >= spa_pkg::MAX_TERMS_DEF) begin
               t.status = spa_pkg::STAT_LOAD_FULL;
            end else if (kind == spa_pkg::REQ_LOAD_A) begin
               a_coefs[a_fill] = coef;
               a_pows[a_fill] = pow;
               a_fill++;
            end else begin
               b_coefs[b_fill] = coef;
               b_pows[b_fill] = pow;
               b_fill++;
            end
            step_terms.push_back(t);
         end
         spa_pkg::REQ_ADD: begin
            if (a_fill == 0 && b_fill == 0) begin
               t.status = spa_pkg::STAT_EMPTY;
               step_terms.push_back(t);
            end else begin
               ia = 0;
               ib = 0;
               t.status = spa_pkg::STAT_SUM_TERM;
               t.last = 1'b0;
               while (ia < a_fill || ib < b_fill) begin
                  if (ia < a_fill && ib < b_fill && a_pows[ia] == b_pows[ib]) begin
                     ca = spa_pkg::SUM_W'(a_coefs[ia]);
                     cb = spa_pkg::SUM_W'(b_coefs[ib]);
                     t.coef = ca + cb;
                     t.pow = a_pows[ia];
                     ia++;
                     ib++;
                  end else if (ia < a_fill && (ib >= b_fill || a_pows[ia] > b_pows[ib])) begin
                     t.coef = spa_pkg::SUM_W'(a_coefs[ia]);
                     t.pow = a_pows[ia];
                     ia++;
                  end else begin
                     t.coef = spa_pkg::SUM_W'(b_coefs[ib]);
                     t.pow = b_pows[ib];
                     ib++;
                  end
                  step_terms.push_back(t);
               end
               step_terms[step_terms.size() - 1].last = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("ERROR at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Offers one request, entered and left at a falling edge.
   task automatic send_request(input spa_pkg::req_code_type kind,
         input logic signed [spa_pkg::COEF_W-1:0] coef,
         input logic [spa_pkg::POW_W-1:0] pow, input bit typed,
         input spa_pkg::status_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_coefficient = coef;
      req_power = pow;
      req_typed = typed;
      req_want = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Prediction and checking share one process so that a request and a
   // response at the same edge are always handled in that order.
   always @(posedge clock) begin : monitor
      sum_term_type want;
      sum_term_type t;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_request(req_kind, req_coefficient, req_power);
            requests_taken++;
            if (req_kind == spa_pkg::REQ_ADD) adds_taken++;
            if (req_typed) begin
               t.status = req_want;
               t.coef = '0;
               t.pow = '0;
               t.last = 1'b1;
               awaited_terms.push_back(t);
            end else begin
               foreach (step_terms[i]) begin
                  awaited_terms.push_back(step_terms[i]);
                  if (step_terms[i].status == spa_pkg::STAT_LOAD_FULL) dropped_loads++;
                  if (step_terms[i].status == spa_pkg::STAT_SUM_TERM &&
                        step_terms[i].coef == 0)
                     zero_sums++;
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_terms.size() == 0) begin
               report_mismatch($sformatf("unexpected term: status %0d coef %0d power %0d last %0b",
                  rsp_status, rsp_sum_coefficient, rsp_sum_power, rsp_last));
            end else begin
               want = awaited_terms.pop_front();
               terms_checked++;
               if (rsp_status !== want.status || rsp_sum_coefficient !== want.coef ||
                     rsp_sum_power !== want.pow || rsp_last !== want.last) begin
                  report_mismatch($sformatf({"expected status %0d coef %0d power %0d last %0b, ",
                     "got status %0d coef %0d power %0d last %0b"},
                     want.status, want.coef, want.pow, want.last,
                     rsp_status, rsp_sum_coefficient, rsp_sum_power, rsp_last));
               end
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is asked for.
   initial begin : receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int                                random_sent;
      int                                pick;
      spa_pkg::req_code_type             kind;
      logic signed [spa_pkg::COEF_W-1:0] coef;
      logic [spa_pkg::POW_W-1:0]         pow;
      logic [spa_pkg::POW_W-1:0]         a_cursor;
      logic [spa_pkg::POW_W-1:0]         b_cursor;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = spa_pkg::REQ_NONE;
      req_coefficient = '0;
      req_power = '0;
      req_typed = 1'b0;
      req_want = spa_pkg::STAT_LOAD_OK;
      a_fill = 0;
      b_fill = 0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      hold_asks = 0;
      mismatch_count = 0;
      requests_taken = 0;
      adds_taken = 0;
      dropped_loads = 0;
      zero_sums = 0;
      terms_checked = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_reqs[i]) begin
         send_request(directed_reqs[i].kind, directed_reqs[i].coef, directed_reqs[i].pow,
            directed_reqs[i].typed, directed_reqs[i].want);
      end

      // Both cursors start at the same power and step down independently,
      // so sorted lists with many shared powers build up.
      a_cursor = 16'($urandom_range(65535, 1000));
      b_cursor = a_cursor;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (random_sent * 3 / RANDOM_ITEMS)
            0: begin
               sender_idle_pct = 14;
               receiver_idle_pct = 84;
            end
            1: begin
               sender_idle_pct = 84;
               receiver_idle_pct = 14;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         pick = $urandom_range(99);
         coef = 16'($urandom);
         pow = 16'($urandom);
         if (pick < 5) begin
            kind = spa_pkg::REQ_NONE;
         end else if (pick < 20) begin
            kind = spa_pkg::REQ_ADD;
         end else begin
            kind = $urandom_range(1) ? spa_pkg::REQ_LOAD_A : spa_pkg::REQ_LOAD_B;
            if ($urandom_range(99) < 80) begin
               if (kind == spa_pkg::REQ_LOAD_A) begin
                  pow = a_cursor;
                  a_cursor = a_cursor - 16'($urandom_range(2, 1));
               end else begin
                  pow = b_cursor;
                  b_cursor = b_cursor - 16'($urandom_range(2, 1));
               end
            end
            if ($urandom_range(9) == 0) begin
               case ($urandom_range(3))
                  0: coef = 16'sh7fff;
                  1: coef = 16'sh8000;
                  2: coef = '0;
                  default: coef = '1;
               endcase
            end
         end
         send_request(kind, coef, pow, 1'b0, spa_pkg::STAT_EMPTY);
         if (kind != spa_pkg::REQ_NONE) begin
            random_sent++;
            // Sender pause: let every outstanding result come back first.
            if (random_sent == 120) begin
               while (awaited_terms.size() != 0) begin
                  req_valid = 1'b0;
                  @(negedge clock);
               end
            end
            // Long receiver hold-off while requests keep coming.
            if (random_sent == 230) hold_asks++;
         end
      end

      while (awaited_terms.size() != 0) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (awaited_terms.size() != 0) begin
         report_mismatch($sformatf("%0d expected terms never arrived", awaited_terms.size()));
      end
      $display("Covered %0d requests (%0d adds, %0d loads dropped on a full list);",
         requests_taken, adds_taken, dropped_loads);
      $display("checked %0d result terms, %0d of them zero sums; %0d mismatches.",
         terms_checked, zero_sums, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
